// ----- hdl/pcsf_pkg.sv -----
// shared types, constants and the command table of the command stream framer
package pcsf_pkg;

    localparam int FRAME_BYTES_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int OFFSET_W = 10;

    localparam logic [7:0] ID_TOOL        = 8'd136;
    localparam logic [7:0] ID_DISPLAY     = 8'd149;
    localparam logic [7:0] ID_BUILD_START = 8'd153;
    localparam logic [7:0] BYTE_NUL       = 8'd0;

    typedef enum logic [2:0] {
        KIND_ID      = 3'd0,
        KIND_FIXED   = 3'd1,
        KIND_TOOLLEN = 3'd2,
        KIND_CHAR    = 3'd3,
        KIND_TERM    = 3'd4
    } t_kind;

    typedef enum logic {
        ERR_NONE    = 1'b0,
        ERR_UNKNOWN = 1'b1
    } t_err;

    // one classified byte, handed from the front through the queue to the back
    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] data;
        t_kind      kind;
        logic       eoc;
        t_err       err;
        logic       first;
    } t_tag;

    typedef struct packed {
        logic       found;
        logic [7:0] len;
    } t_lookup;

    // known command ids and the fixed bytes read before any length or string
    function automatic t_lookup cmd_lookup(input logic [7:0] id);
        t_lookup r;
        r.found = 1'b1;
        r.len   = 8'd0;
        case (id)
            8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11,
            8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20,
            8'd21, 8'd22, 8'd23, 8'd24, 8'd27, 8'd112: r.len = 8'd0;
            8'd131, 8'd132: r.len = 8'd7;
            8'd133, 8'd148, 8'd149, 8'd153: r.len = 8'd4;
            8'd134, 8'd137, 8'd143, 8'd144, 8'd151, 8'd152, 8'd154,
            8'd156: r.len = 8'd1;
            8'd135, 8'd141, 8'd146, 8'd147: r.len = 8'd5;
            8'd136, 8'd138, 8'd145, 8'd150: r.len = 8'd2;
            8'd139: r.len = 8'd24;
            8'd140: r.len = 8'd20;
            8'd142: r.len = 8'd25;
            8'd155: r.len = 8'd31;
            default: begin
                r.found = 1'b0;
                r.len   = 8'd0;
            end
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/pcsf_front.sv -----
// front end: command parser that classifies each accepted byte
module pcsf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [7:0]            i_byte,
    input  logic                  i_full,
    output logic                  o_push,
    output pcsf_pkg::t_tag        o_tag
);

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_FIXED     = 5'b00010,
        PH_TOOL_LEN  = 5'b00100,
        PH_TOOL_DATA = 5'b01000,
        PH_STRING    = 5'b10000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_rem, n_rem;
    logic [7:0] rem_dec;
    pcsf_pkg::t_lookup lk;
    pcsf_pkg::t_tag    tag;

    function automatic t_phase after_fixed(input logic [7:0] cmd);
        t_phase p;
        if (cmd == pcsf_pkg::ID_TOOL) begin
            p = PH_TOOL_LEN;
        end else if (cmd == pcsf_pkg::ID_DISPLAY || cmd == pcsf_pkg::ID_BUILD_START) begin
            p = PH_STRING;
        end else begin
            p = PH_IDLE;
        end
        return p;
    endfunction

    assign o_push = i_push && !i_full;
    assign o_tag  = tag;

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_rem     = r_rem;
        rem_dec   = r_rem - 8'd1;
        lk        = pcsf_pkg::cmd_lookup(i_byte);
        tag.cmd   = r_cmd;
        tag.data  = i_byte;
        tag.kind  = pcsf_pkg::KIND_FIXED;
        tag.eoc   = 1'b0;
        tag.err   = pcsf_pkg::ERR_NONE;
        tag.first = 1'b0;
        case (r_phase)
            PH_FIXED: begin
                n_rem = rem_dec;
                if (rem_dec == 8'd0) begin
                    n_phase = after_fixed(r_cmd);
                    tag.eoc = (n_phase == PH_IDLE);
                end
            end
            PH_TOOL_LEN: begin
                tag.kind = pcsf_pkg::KIND_TOOLLEN;
                n_rem    = i_byte;
                if (i_byte == 8'd0) begin
                    n_phase = PH_IDLE;
                    tag.eoc = 1'b1;
                end else begin
                    n_phase = PH_TOOL_DATA;
                end
            end
            PH_TOOL_DATA: begin
                n_rem = rem_dec;
                if (rem_dec == 8'd0) begin
                    n_phase = PH_IDLE;
                    tag.eoc = 1'b1;
                end
            end
            PH_STRING: begin
                if (i_byte == pcsf_pkg::BYTE_NUL) begin
                    tag.kind = pcsf_pkg::KIND_TERM;
                    tag.eoc  = 1'b1;
                    n_phase  = PH_IDLE;
                end else begin
                    tag.kind = pcsf_pkg::KIND_CHAR;
                end
            end
            default: begin
                // idle: this byte is a command id
                tag.first = 1'b1;
                tag.kind  = pcsf_pkg::KIND_ID;
                tag.cmd   = i_byte;
                n_cmd     = i_byte;
                if (!lk.found) begin
                    tag.err = pcsf_pkg::ERR_UNKNOWN;
                    tag.eoc = 1'b1;
                    n_rem   = 8'd0;
                    n_phase = PH_IDLE;
                end else begin
                    n_rem   = lk.len;
                    n_phase = (lk.len != 8'd0) ? PH_FIXED : after_fixed(i_byte);
                    tag.eoc = (n_phase == PH_IDLE);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cmd   <= 8'd0;
            r_rem   <= 8'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_rem   <= n_rem;
        end
    end

endmodule

// ----- hdl/pcsf_queue.sv -----
// short queue of classified items between the front and the back
module pcsf_queue #(
    parameter int DEPTH = pcsf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcsf_pkg::t_tag i_tag,
    input  logic           i_pop,
    output pcsf_pkg::t_tag o_tag,
    output logic           o_full,
    output logic           o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    pcsf_pkg::t_tag r_mem [DEPTH];
    logic [AW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_tag   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hdl/pcsf_back.sv -----
// back end: frame offset counter and output register
module pcsf_back #(
    parameter int FRAME_BYTES = pcsf_pkg::FRAME_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  pcsf_pkg::t_tag i_q_tag,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_command_id,
    output logic [7:0]     o_data_byte,
    output logic [9:0]     o_byte_offset,
    output logic [2:0]     o_byte_kind,
    output logic           o_end_of_command,
    output logic           o_error_code
);

    localparam int LW = $clog2(FRAME_BYTES);
    localparam int CW = (LW > pcsf_pkg::OFFSET_W) ? LW : pcsf_pkg::OFFSET_W;
    localparam logic [CW-1:0] LIMIT = CW'(FRAME_BYTES - 1);

    logic           r_vld;
    logic [CW-1:0]  r_off, n_off;
    pcsf_pkg::t_tag r_tag;
    logic           load;

    assign load    = !i_q_empty && (!r_vld || i_pop);
    assign o_q_pop = load;
    assign n_off   = i_q_tag.first ? '0 : ((r_off < LIMIT) ? r_off + CW'(1) : LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_off <= '0;
        end else begin
            if (load) begin
                r_vld <= 1'b1;
                r_off <= n_off;
            end else if (i_pop) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tag <= i_q_tag;
        end
    end

    assign o_empty          = !r_vld;
    assign o_command_id     = r_tag.cmd;
    assign o_data_byte      = r_tag.data;
    assign o_byte_offset    = r_off[pcsf_pkg::OFFSET_W-1:0];
    assign o_byte_kind      = r_tag.kind;
    assign o_end_of_command = r_tag.eoc;
    assign o_error_code     = r_tag.err;

endmodule

// ----- hdl/printer_command_stream_framer.sv -----
// top level of the printer command stream framer
//
//  channel   | handshake          | fields
//  ----------+--------------------+-----------------------------------------------
//  input     | push / full        | i_stream_byte
//  result    | empty / pop        | o_command_id, o_data_byte, o_byte_offset,
//            |                    | o_byte_kind, o_end_of_command, o_error_code
//
// one item per cycle in and out when not stalled; each input byte gives exactly one result
// each result goes through the queue into the output register, loaded once the output is free
// the parser state only advances on the push edge, so bytes follow back to back
// full rises only when the inner queue holds QUEUE_DEPTH items behind a stalled pop
// synchronous active-low reset returns the parser to idle and empties the queue
module printer_command_stream_framer #(
    parameter int FRAME_BYTES = pcsf_pkg::FRAME_BYTES_DEF,
    parameter int QUEUE_DEPTH = pcsf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input side
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_stream_byte,
    // result side
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_command_id,
    output logic [7:0] o_data_byte,
    output logic [9:0] o_byte_offset,
    output logic [2:0] o_byte_kind,
    output logic       o_end_of_command,
    output logic       o_error_code
);

    // front to queue
    logic           f_push;
    pcsf_pkg::t_tag f_tag;
    // queue to back
    logic           q_empty, q_pop;
    pcsf_pkg::t_tag q_tag;

    // parser: classifies each byte as it is accepted
    pcsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_byte  (i_stream_byte),
        .i_full  (full),
        .o_push  (f_push),
        .o_tag   (f_tag)
    );

    // decouples the parser from a stalled consumer
    pcsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_tag   (f_tag),
        .i_pop   (q_pop),
        .o_tag   (q_tag),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // offset tracking and the registered result
    pcsf_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_tag          (q_tag),
        .o_q_pop          (q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_command_id     (o_command_id),
        .o_data_byte      (o_data_byte),
        .o_byte_offset    (o_byte_offset),
        .o_byte_kind      (o_byte_kind),
        .o_end_of_command (o_end_of_command),
        .o_error_code     (o_error_code)
    );

endmodule

// ----- hdl/pcsf_checker.sv -----
// port-level checks for the command stream framer and their bind
module pcsf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_data_byte,
    input logic [9:0] o_byte_offset,
    input logic [2:0] o_byte_kind,
    input logic       o_end_of_command,
    input logic       o_error_code
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_data_byte) && $stable(o_byte_offset))
        else $error("stalled item changed");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_byte_kind <= pcsf_pkg::KIND_TERM)
        else $error("byte kind out of range");

    a_id_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_byte_kind == pcsf_pkg::KIND_ID |-> o_byte_offset == 10'd0)
        else $error("id item with nonzero offset");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_error_code |-> o_end_of_command && o_byte_kind == pcsf_pkg::KIND_ID)
        else $error("unknown id item not a closed id item");

endmodule

bind printer_command_stream_framer pcsf_checker u_pcsf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .empty            (empty),
    .pop              (pop),
    .o_data_byte      (o_data_byte),
    .o_byte_offset    (o_byte_offset),
    .o_byte_kind      (o_byte_kind),
    .o_end_of_command (o_end_of_command),
    .o_error_code     (o_error_code)
);
